// File: hdl/pmrs_pkg.sv
package pmrs_pkg;

  // Position register width and the fixed width of the target field.
  localparam int PosW = 32;
  localparam int SpeedW = 31;
  localparam int CntW = 8;
  localparam int RetryW = 4;

  localparam logic [SpeedW-1:0] SpeedReset = SpeedW'(100);

  // Settle detection thresholds.
  localparam int StallMove = 3;
  localparam int NearWindow = 10;
  localparam int SettleCount = 5;
  localparam int StallLimit = 200;
  localparam int RetryStep = 2;
  localparam int RetryErrorAt = 3;

  // Input item modes.
  localparam logic [1:0] ModeTick = 2'd0;
  localparam logic [1:0] ModeStart = 2'd1;
  localparam logic [1:0] ModeClear = 2'd2;

  // Move status codes.
  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StRunning = 2'd1;
  localparam logic [1:0] StCompleted = 2'd2;
  localparam logic [1:0] StError = 2'd3;

  typedef struct packed {
    logic signed [PosW-1:0] position;
    logic signed [PosW-1:0] previous_position;
    logic [CntW-1:0] stall_count;
    logic [CntW-1:0] near_count;
    logic [RetryW-1:0] retry_count;
    logic [1:0] run_status;
  } axis_state_t;

  typedef struct packed {
    logic signed [31:0] actual_position;
    logic [1:0] move_status;
    logic retry_issued;
    logic report_event;
  } result_t;

endpackage

// File: hdl/pmrs_step.sv
module pmrs_step (
  input  pmrs_pkg::axis_state_t cur_i,
  input  logic [pmrs_pkg::SpeedW-1:0] speed_i,
  input  logic [1:0] mode_i,
  input  logic signed [31:0] target_i,
  output pmrs_pkg::axis_state_t nxt_o,
  output pmrs_pkg::result_t res_o
);

  localparam int XW = pmrs_pkg::PosW + 1;

  logic signed [XW-1:0] pos_x;
  logic signed [XW-1:0] tgt_x;
  logic signed [XW-1:0] diff;
  logic move_up;
  logic [XW-1:0] abs_gap;
  logic [XW-1:0] speed_x;
  logic far;
  logic signed [pmrs_pkg::PosW-1:0] new_pos;
  logic [XW-1:0] remain;
  logic signed [XW-1:0] moved_s;
  logic [XW-1:0] moved;
  logic stall_hit;
  logic near_hit;
  logic [pmrs_pkg::CntW-1:0] stall_inc;
  logic [pmrs_pkg::CntW-1:0] near_inc;
  logic [pmrs_pkg::RetryW:0] retry_sum;
  logic retried;
  logic reported;

  // Slew limit: move by the profile speed, or land on the target when closer.
  always_comb begin
    pos_x = XW'(cur_i.position);
    tgt_x = XW'(target_i);
    diff = tgt_x - pos_x;
    move_up = (diff > 0);
    abs_gap = move_up ? XW'(diff) : XW'(pos_x - tgt_x);
    speed_x = XW'(speed_i);
    far = (abs_gap > speed_x);
    if (!far) begin
      new_pos = pmrs_pkg::PosW'(target_i);
    end else if (move_up) begin
      new_pos = cur_i.position + pmrs_pkg::PosW'(speed_i);
    end else begin
      new_pos = cur_i.position - pmrs_pkg::PosW'(speed_i);
    end
    remain = far ? (abs_gap - speed_x) : '0;
    moved_s = XW'(new_pos) - XW'(cur_i.previous_position);
    moved = moved_s[XW-1] ? XW'(-moved_s) : XW'(moved_s);
    stall_hit = (moved < XW'(pmrs_pkg::StallMove));
    near_hit = (remain < XW'(pmrs_pkg::NearWindow));
  end

  always_comb begin
    nxt_o = cur_i;
    retried = 1'b0;
    reported = 1'b0;
    stall_inc = cur_i.stall_count;
    near_inc = cur_i.near_count;
    retry_sum = (pmrs_pkg::RetryW + 1)'(cur_i.retry_count)
              + (pmrs_pkg::RetryW + 1)'(pmrs_pkg::RetryStep);
    case (mode_i)
      pmrs_pkg::ModeTick: begin
        nxt_o.position = new_pos;
        if (cur_i.run_status == pmrs_pkg::StRunning) begin
          if (stall_hit && (cur_i.stall_count != '1)) begin
            stall_inc = cur_i.stall_count + 1'b1;
          end
          if (near_hit && (cur_i.near_count != '1)) begin
            near_inc = cur_i.near_count + 1'b1;
          end
          nxt_o.stall_count = stall_inc;
          nxt_o.near_count = near_inc;
          if ((near_inc > pmrs_pkg::CntW'(pmrs_pkg::SettleCount))
              && (stall_inc > pmrs_pkg::CntW'(pmrs_pkg::SettleCount))) begin
            nxt_o.near_count = pmrs_pkg::CntW'(pmrs_pkg::NearWindow);
            nxt_o.run_status = pmrs_pkg::StCompleted;
            reported = 1'b1;
          end else if (32'(stall_inc) > 32'(pmrs_pkg::StallLimit)) begin
            nxt_o.stall_count = '0;
            nxt_o.near_count = '0;
            retried = 1'b1;
            nxt_o.retry_count = retry_sum[pmrs_pkg::RetryW] ? '1
                              : retry_sum[pmrs_pkg::RetryW-1:0];
            // Two earlier reissues leave the count at four, so this third one fails.
            if (cur_i.retry_count >= pmrs_pkg::RetryW'(pmrs_pkg::RetryErrorAt)) begin
              nxt_o.run_status = pmrs_pkg::StError;
              reported = 1'b1;
            end
          end
          nxt_o.previous_position = new_pos;
        end
      end
      pmrs_pkg::ModeStart: begin
        if (cur_i.run_status == pmrs_pkg::StIdle) begin
          nxt_o.run_status = pmrs_pkg::StRunning;
          nxt_o.stall_count = '0;
          nxt_o.near_count = '0;
          nxt_o.retry_count = '0;
        end
      end
      pmrs_pkg::ModeClear: begin
        nxt_o.run_status = pmrs_pkg::StIdle;
      end
      default: begin
      end
    endcase
    res_o.actual_position = 32'(nxt_o.position);
    res_o.move_status = nxt_o.run_status;
    res_o.retry_issued = retried;
    res_o.report_event = reported;
  end

endmodule

// File: hdl/position_move_ramp_settle.sv
// Simulated profile-position axis with slew-rate limiting and settle detection.
// Every input transfer produces exactly one result transfer. A tick (mode 0)
// moves the position toward target_position_i by at most the profile speed;
// while a move runs, it counts ticks that barely moved and ticks that ended
// near the target, reports completion when both pass five, and reissues the
// move after a long stall, reporting an error on the third reissue. A start
// (mode 1) begins a move only from idle, and a clear (mode 2) returns the
// status to idle. Throughput is one item per clock while in_stall_o is low:
// the whole update is a single pass of add, clamp and compare logic from the
// state registers into the result register, so back-to-back transfers need
// no wait, and each result is registered. A two-entry output buffer (result
// register plus skid register) lets the block keep taking items while a
// result waits; in_stall_o is raised only when both entries are full and comes
// straight from a flop. The profile speed register resets to 100. The user must
// write it through cfg_we_i / cfg_wdata_i while idle, which is not enforced.
module position_move_ramp_settle (
  input  logic clk_i,
  input  logic rst_ni,

  input  logic cfg_we_i,
  input  logic [pmrs_pkg::SpeedW-1:0] cfg_wdata_i,

  input  logic in_valid_i,
  output logic in_stall_o,
  input  logic [1:0] mode_i,
  input  logic signed [31:0] target_position_i,

  output logic out_valid_o,
  input  logic out_stall_i,
  output logic signed [31:0] actual_position_o,
  output logic [1:0] move_status_o,
  output logic retry_issued_o,
  output logic report_event_o
);

  // Axis state and configuration.
  pmrs_pkg::axis_state_t state_q, state_d;
  logic [pmrs_pkg::SpeedW-1:0] speed_q;

  // Output buffering: main result register and the skid entry behind it.
  pmrs_pkg::result_t res_d;
  pmrs_pkg::result_t out_q;
  pmrs_pkg::result_t skid_q;
  logic out_valid_q;
  logic skid_valid_q;

  logic in_xfer;
  logic out_xfer;

  assign in_xfer = in_valid_i && !skid_valid_q;
  assign out_xfer = out_valid_q && !out_stall_i;

  pmrs_step u_step (
    .cur_i    (state_q),
    .speed_i  (speed_q),
    .mode_i   (mode_i),
    .target_i (target_position_i),
    .nxt_o    (state_d),
    .res_o    (res_d)
  );

  // The axis state advances on each accepted item.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.position <= '0;
      state_q.previous_position <= '0;
      state_q.stall_count <= '0;
      state_q.near_count <= '0;
      state_q.retry_count <= '0;
      state_q.run_status <= pmrs_pkg::StIdle;
    end else if (in_xfer) begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      speed_q <= pmrs_pkg::SpeedReset;
    end else if (cfg_we_i) begin
      speed_q <= cfg_wdata_i;
    end
  end

  // Valid flags of the two result entries. When the skid entry is full the
  // input is stalled, so the only event then is the main entry draining.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (out_xfer) begin
        skid_valid_q <= 1'b0;
      end
    end else if (in_xfer) begin
      if (out_valid_q && !out_xfer) begin
        skid_valid_q <= 1'b1;
      end else begin
        out_valid_q <= 1'b1;
      end
    end else if (out_xfer) begin
      out_valid_q <= 1'b0;
    end
  end

  // Result payload moves without reset; only the valid flags matter.
  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (out_xfer) begin
        out_q <= skid_q;
      end
    end else if (in_xfer) begin
      if (out_valid_q && !out_xfer) begin
        skid_q <= res_d;
      end else begin
        out_q <= res_d;
      end
    end
  end

  assign in_stall_o = skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign actual_position_o = out_q.actual_position;
  assign move_status_o = out_q.move_status;
  assign retry_issued_o = out_q.retry_issued;
  assign report_event_o = out_q.report_event;

endmodule
